FILE: rtl/gcv_pkg.sv
`default_nettype none

package gcv_pkg;

    // grid limits
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_DIM     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int CELL_TOTAL  = MAX_COLUMNS * MAX_ROWS;

    // widths
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int IX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W  = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int COORD_W = 16;
    localparam int IN_W    = 18;
    localparam int ACC_W   = COORD_W + CNT_W;
    localparam int SW      = ((ACC_W > 19) ? ACC_W : 19) + 2;
    localparam int PW      = 2 * SW;

    // cell state codes
    localparam logic [1:0] CELL_HIDDEN   = 2'd0;
    localparam logic [1:0] CELL_EXPLORED = 2'd1;
    localparam logic [1:0] CELL_VISIBLE  = 2'd2;

    // op codes
    localparam logic [1:0] OP_AGE    = 2'd0;
    localparam logic [1:0] OP_REVEAL = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // register indexes and reset values
    localparam logic [1:0]  CFG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0]  CFG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0]  CFG_CELL_EDGE  = 2'd2;
    localparam logic [15:0] RST_MAP_WIDTH  = 16'd1024;
    localparam logic [15:0] RST_MAP_HEIGHT = 16'd1024;
    localparam logic [15:0] RST_CELL_EDGE  = 16'd16;

    // memory port request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [1:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

FILE: rtl/grid_circle_visibility_map_unit.sv
`default_nettype none

// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------------
// input     | in        | i_in_valid / o_in_stall   | i_op, i_point_x, i_point_y, i_circle_radius
// output    | out       | o_out_valid / i_out_stall | o_cell_state, o_overlap_found
// config    | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// after reset and after each config write: the column and row counts are found,
// then a clearing pass writes all CELL_TOTAL (4096) cells; input is stalled meanwhile
// age: a read and a write-back per cell; read point: a column search, a row search, then a memory read
// reveal/query: four index searches for the box bounds, the radius squared, then a
// squared gap per box row and per box cell, all on one shared multiplier and index stepper
// one transaction at a time; a finished result waits in the output register

module grid_circle_visibility_map_unit import gcv_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [15:0]            i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_op,
    input  wire logic signed [IN_W-1:0] i_point_x,
    input  wire logic signed [IN_W-1:0] i_point_y,
    input  wire logic signed [IN_W-1:0] i_circle_radius,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [1:0]                  o_cell_state,
    output logic                        o_overlap_found
);

    typedef enum logic [4:0] {
        S_CFG, S_CNT_COL, S_CNT_ROW, S_CLEAR, S_IDLE,
        S_AGE_RD, S_AGE_WR, S_PT_CHK, S_PT_RD, S_PT_DAT,
        S_CHK, S_IXLD, S_IX, S_RSQ, S_RSQ_M, S_ROW, S_ROW_M,
        S_CELL, S_CELL_M, S_TEST, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_C0, PH_C1, PH_R0, PH_R1, PH_PC, PH_PR
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [15:0] r_map_width, r_map_height, r_cell_edge;
    logic [CNT_W-1:0] r_cc, r_rc, r_cnt;
    logic [ADDR_W-1:0] r_ptr, r_base, r_ixbase;
    logic [ACC_W-1:0] r_acc, r_x0, r_x0c0, r_y0;
    logic [IX_W-1:0] r_idx, r_c0, r_c1, r_r1, r_col, r_row;
    logic [15:0] r_ixv;
    logic [1:0] r_op;
    logic signed [SW-1:0] r_cx, r_cy, r_rad, r_d;
    logic [PW-1:0] r_r2, r_dy2, r_dx2;
    logic [1:0] r_state_res, r_out_state;
    logic r_hit_res, r_out_valid, r_out_hit;

    logic [15:0] cell_len;
    logic [ACC_W-1:0] len_ext;
    logic [ADDR_W-1:0] cell_addr;
    logic [1:0] ram_rdata;
    t_ram_req ram_req;
    logic signed [PW-1:0] prod;
    logic [PW:0] dist2;
    logic hit;
    logic ix_row, ix_go;
    logic [CNT_W-1:0] ix_lim;
    logic [ACC_W-1:0] xe, x1, ye, y1;
    logic signed [SW-1:0] gap_x, gap_y;
    logic signed [SW-1:0] w_s, h_s;
    logic off_circle, off_point, cfg_hit;
    logic [15:0] ix_v;

    // clamp a signed value into [0, ext]
    function automatic logic [15:0] clamp0(input logic signed [SW-1:0] v,
                                           input logic [15:0] ext);
        logic signed [SW-1:0] e_s;
        e_s = $signed({{(SW-16){1'b0}}, ext});
        if (v < 0) begin
            clamp0 = '0;
        end else if (v > e_s) begin
            clamp0 = ext;
        end else begin
            clamp0 = v[15:0];
        end
    endfunction

    // signed distance from c to the interval [lo, hi]
    function automatic logic signed [SW-1:0] axis_gap(input logic signed [SW-1:0] c,
                                                      input logic [ACC_W-1:0] lo,
                                                      input logic [ACC_W-1:0] hi);
        logic signed [SW-1:0] lo_s, hi_s;
        lo_s = $signed({{(SW-ACC_W){1'b0}}, lo});
        hi_s = $signed({{(SW-ACC_W){1'b0}}, hi});
        if (c < lo_s) begin
            axis_gap = c - lo_s;
        end else if (c > hi_s) begin
            axis_gap = c - hi_s;
        end else begin
            axis_gap = '0;
        end
    endfunction

    assign cell_len  = (r_cell_edge == 16'd0) ? 16'd1 : r_cell_edge;
    assign len_ext   = ACC_W'(cell_len);
    assign cell_addr = r_base + ADDR_W'(r_col);
    assign w_s       = $signed({{(SW-16){1'b0}}, r_map_width});
    assign h_s       = $signed({{(SW-16){1'b0}}, r_map_height});

    // shared multiplier, always squares r_d
    assign prod  = r_d * r_d;
    assign dist2 = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign hit   = dist2 <= {1'b0, r_r2};

    // closest point of the clipped cell rectangle
    assign xe    = r_x0 + len_ext;
    assign x1    = (xe < ACC_W'(r_map_width)) ? xe : ACC_W'(r_map_width);
    assign ye    = r_y0 + len_ext;
    assign y1    = (ye < ACC_W'(r_map_height)) ? ye : ACC_W'(r_map_height);
    assign gap_x = axis_gap(r_cx, r_x0, x1);
    assign gap_y = axis_gap(r_cy, r_y0, y1);

    // map range checks
    assign off_circle = (r_cx + r_rad < 0) || (r_cy + r_rad < 0)
                     || (r_cx - r_rad > w_s) || (r_cy - r_rad > h_s);
    assign off_point  = (r_cx < 0) || (r_cy < 0) || (r_cx > w_s) || (r_cy > h_s);
    assign cfg_hit    = i_cfg_we && ((i_cfg_index == CFG_MAP_WIDTH)
                     || (i_cfg_index == CFG_MAP_HEIGHT) || (i_cfg_index == CFG_CELL_EDGE));

    // index stepper: value and limit per phase
    always_comb begin
        ix_v = '0;
        unique case (r_phase)
            PH_C0: ix_v = clamp0(r_cx - r_rad, r_map_width);
            PH_C1: ix_v = clamp0(r_cx + r_rad, r_map_width);
            PH_R0: ix_v = clamp0(r_cy - r_rad, r_map_height);
            PH_R1: ix_v = clamp0(r_cy + r_rad, r_map_height);
            PH_PC: ix_v = r_cx[15:0];
            PH_PR: ix_v = r_cy[15:0];
            default: ix_v = '0;
        endcase
    end

    assign ix_row = (r_phase == PH_R0) || (r_phase == PH_R1) || (r_phase == PH_PR);
    assign ix_lim = ix_row ? r_rc : r_cc;
    assign ix_go  = ((CNT_W'(r_idx) + CNT_W'(1)) < ix_lim) && (r_acc <= ACC_W'(r_ixv));

    // memory requests
    always_comb begin
        ram_req = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_ptr;
                ram_req.wdata = CELL_HIDDEN;
            end
            S_AGE_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = r_ptr;
            end
            S_AGE_WR: begin
                ram_req.we    = (ram_rdata == CELL_VISIBLE);
                ram_req.waddr = r_ptr;
                ram_req.wdata = CELL_EXPLORED;
            end
            S_PT_RD, S_CELL: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = cell_addr;
            end
            S_TEST: begin
                ram_req.we    = (r_op == OP_REVEAL) && hit;
                ram_req.waddr = cell_addr;
                ram_req.wdata = CELL_VISIBLE;
            end
            default: ram_req = '0;
        endcase
    end

    gcv_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CFG;
            r_phase      <= PH_C0;
            r_map_width  <= RST_MAP_WIDTH;
            r_map_height <= RST_MAP_HEIGHT;
            r_cell_edge  <= RST_CELL_EDGE;
            r_out_valid  <= 1'b0;
        end else begin
            // result taken and no new one loaded this cycle
            if (r_out_valid && !i_out_stall && (cfg_hit || (r_state != S_DONE))) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_hit) begin
                // config write: update and rebuild the grid
                unique case (i_cfg_index)
                    CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                    CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                    default:        r_cell_edge  <= i_cfg_data;
                endcase
                r_state <= S_CFG;
            end else begin
            unique case (r_state)
                S_CFG: begin
                    r_cnt   <= CNT_W'(1);
                    r_acc   <= len_ext;
                    r_state <= S_CNT_COL;
                end
                S_CNT_COL: begin
                    if ((r_acc < ACC_W'(r_map_width)) && (r_cnt < CNT_W'(MAX_COLUMNS))) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_acc <= r_acc + len_ext;
                    end else begin
                        r_cc    <= r_cnt;
                        r_cnt   <= CNT_W'(1);
                        r_acc   <= len_ext;
                        r_state <= S_CNT_ROW;
                    end
                end
                S_CNT_ROW: begin
                    if ((r_acc < ACC_W'(r_map_height)) && (r_cnt < CNT_W'(MAX_ROWS))) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_acc <= r_acc + len_ext;
                    end else begin
                        r_rc    <= r_cnt;
                        r_ptr   <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    r_ptr <= r_ptr + ADDR_W'(1);
                    if (r_ptr == ADDR_W'(CELL_TOTAL - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op        <= i_op;
                        r_cx        <= SW'(i_point_x);
                        r_cy        <= SW'(i_point_y);
                        r_rad       <= (i_circle_radius < 0) ? '0 : SW'(i_circle_radius);
                        r_state_res <= CELL_HIDDEN;
                        r_hit_res   <= 1'b0;
                        r_ptr       <= '0;
                        priority case (i_op)
                            OP_AGE:  r_state <= S_AGE_RD;
                            OP_READ: r_state <= S_PT_CHK;
                            default: r_state <= S_CHK;
                        endcase
                    end
                end
                S_AGE_RD: begin
                    r_state <= S_AGE_WR;
                end
                S_AGE_WR: begin
                    r_ptr <= r_ptr + ADDR_W'(1);
                    if (r_ptr == ADDR_W'(CELL_TOTAL - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_AGE_RD;
                    end
                end
                S_PT_CHK: begin
                    if (off_point) begin
                        r_state <= S_DONE;
                    end else begin
                        r_phase <= PH_PC;
                        r_state <= S_IXLD;
                    end
                end
                S_PT_RD: begin
                    r_state <= S_PT_DAT;
                end
                S_PT_DAT: begin
                    r_state_res <= ram_rdata;
                    r_state     <= S_DONE;
                end
                S_CHK: begin
                    if (off_circle) begin
                        r_state <= S_DONE;
                    end else begin
                        r_phase <= PH_C0;
                        r_state <= S_IXLD;
                    end
                end
                // start one index search
                S_IXLD: begin
                    r_ixv    <= ix_v;
                    r_idx    <= '0;
                    r_acc    <= len_ext;
                    r_ixbase <= '0;
                    r_state  <= S_IX;
                end
                // one column or row per cycle until the coordinate is passed or the last one is reached
                S_IX: begin
                    if (ix_go) begin
                        r_idx <= r_idx + IX_W'(1);
                        r_acc <= r_acc + len_ext;
                        if (ix_row) begin
                            r_ixbase <= r_ixbase + ADDR_W'(r_cc);
                        end
                    end else begin
                        unique case (r_phase)
                            PH_C0: begin
                                r_c0    <= r_idx;
                                r_x0c0  <= r_acc - len_ext;
                                r_phase <= PH_C1;
                                r_state <= S_IXLD;
                            end
                            PH_C1: begin
                                r_c1    <= r_idx;
                                r_phase <= PH_R0;
                                r_state <= S_IXLD;
                            end
                            PH_R0: begin
                                r_row   <= r_idx;
                                r_y0    <= r_acc - len_ext;
                                r_base  <= r_ixbase;
                                r_phase <= PH_R1;
                                r_state <= S_IXLD;
                            end
                            PH_R1: begin
                                r_r1    <= r_idx;
                                r_state <= S_RSQ;
                            end
                            PH_PC: begin
                                r_col   <= r_idx;
                                r_phase <= PH_PR;
                                r_state <= S_IXLD;
                            end
                            PH_PR: begin
                                r_base  <= r_ixbase;
                                r_state <= S_PT_RD;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RSQ: begin
                    r_d     <= r_rad;
                    r_state <= S_RSQ_M;
                end
                S_RSQ_M: begin
                    r_r2    <= PW'(prod);
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_d     <= gap_y;
                    r_state <= S_ROW_M;
                end
                S_ROW_M: begin
                    r_dy2   <= PW'(prod);
                    r_col   <= r_c0;
                    r_x0    <= r_x0c0;
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    r_d     <= gap_x;
                    r_state <= S_CELL_M;
                end
                S_CELL_M: begin
                    r_dx2   <= PW'(prod);
                    r_state <= S_TEST;
                end
                // distance test; a query hit ends the search, else next cell of the box
                S_TEST: begin
                    if ((r_op == OP_QUERY) && hit && (ram_rdata == CELL_VISIBLE)) begin
                        r_hit_res <= 1'b1;
                        r_state   <= S_DONE;
                    end else if (r_col < r_c1) begin
                        r_col   <= r_col + IX_W'(1);
                        r_x0    <= r_x0 + len_ext;
                        r_state <= S_CELL;
                    end else if (r_row < r_r1) begin
                        r_row   <= r_row + IX_W'(1);
                        r_y0    <= r_y0 + len_ext;
                        r_base  <= r_base + ADDR_W'(r_cc);
                        r_state <= S_ROW;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_state <= r_state_res;
                        r_out_hit   <= r_hit_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            end
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cell_state    = r_out_state;
    assign o_overlap_found = r_out_hit;

endmodule

`default_nettype wire

FILE: rtl/gcv_cell_ram.sv
`default_nettype none

module gcv_cell_ram import gcv_pkg::*; (
    input  wire logic       i_clk,
    input  wire t_ram_req   i_req,
    output logic [1:0]      o_rdata
);

    logic [1:0] r_mem [CELL_TOTAL];
    logic [1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: tb/sv/grid_circle_visibility_map_checker.sv
`default_nettype none

module grid_circle_visibility_map_checker import gcv_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [15:0]            i_cfg_data,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire logic [1:0]             i_op,
    input  wire logic signed [IN_W-1:0] i_point_x,
    input  wire logic signed [IN_W-1:0] i_point_y,
    input  wire logic signed [IN_W-1:0] i_circle_radius,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic [1:0]             i_cell_state,
    input  wire logic                   i_overlap_found,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic [1:0] cell_state;
        logic       overlap_found;
    } t_grid_answer;

    // shadow copy of the grid and its configuration
    logic [15:0]  map_w;
    logic [15:0]  map_h;
    logic [15:0]  cell_len;
    logic [1:0]   shadow_cells [CELL_TOTAL];
    int           cols;
    int           rows;
    t_grid_answer answer_q [$];

    function automatic longint edge_units();
        return (cell_len == 16'd0) ? 64'sd1 : longint'(cell_len);
    endfunction

    function automatic int grid_count(longint extent, int limit);
        longint n;
        n = (extent + edge_units() - 1) / edge_units();
        if (n < 1) n = 1;
        if (n > limit) n = limit;
        return int'(n);
    endfunction

    // recompute counts and wipe the grid
    function automatic void rebuild_grid();
        cols = grid_count(longint'(map_w), MAX_COLUMNS);
        rows = grid_count(longint'(map_h), MAX_ROWS);
        foreach (shadow_cells[k]) shadow_cells[k] = CELL_HIDDEN;
    endfunction

    function automatic int cell_of(longint v, int count);
        longint c;
        c = v / edge_units();
        if (c > count - 1) c = count - 1;
        return int'(c);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // nearest point of the clipped cell rectangle within the radius
    function automatic bit cell_in_circle(int col, int row, longint cx, longint cy,
                                          longint r);
        longint e, x0, x1, y0, y1, dx, dy;
        e  = edge_units();
        x0 = longint'(col) * e;
        x1 = (x0 + e < longint'(map_w)) ? x0 + e : longint'(map_w);
        y0 = longint'(row) * e;
        y1 = (y0 + e < longint'(map_h)) ? y0 + e : longint'(map_h);
        dx = cx - clip(cx, x0, x1);
        dy = cy - clip(cy, y0, y1);
        return (dx * dx + dy * dy <= r * r);
    endfunction

    // reveal marks cells, query reports a visible hit
    function automatic bit sweep_circle(longint cx, longint cy, longint r, bit reveal);
        longint w, h;
        int     c0, c1, r0, r1, idx;
        w = longint'(map_w);
        h = longint'(map_h);
        if (r < 0) r = 0;
        if (cx + r < 0 || cy + r < 0 || cx - r > w || cy - r > h) return 1'b0;
        c0 = cell_of(clip(cx - r, 0, w), cols);
        c1 = cell_of(clip(cx + r, 0, w), cols);
        r0 = cell_of(clip(cy - r, 0, h), rows);
        r1 = cell_of(clip(cy + r, 0, h), rows);
        for (int row = r0; row <= r1; row++) begin
            for (int col = c0; col <= c1; col++) begin
                idx = (row * cols + col) % CELL_TOTAL;
                if (reveal) begin
                    if (cell_in_circle(col, row, cx, cy, r)) shadow_cells[idx] = CELL_VISIBLE;
                end else if (shadow_cells[idx] == CELL_VISIBLE &&
                             cell_in_circle(col, row, cx, cy, r)) begin
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_grid_answer apply_grid_op(logic [1:0] op, longint px, longint py,
                                                   longint r);
        t_grid_answer ans;
        ans = '0;
        case (op)
            OP_AGE: begin
                foreach (shadow_cells[k])
                    if (shadow_cells[k] == CELL_VISIBLE) shadow_cells[k] = CELL_EXPLORED;
            end
            OP_REVEAL: begin
                void'(sweep_circle(px, py, r, 1'b1));
            end
            OP_READ: begin
                if (!(px < 0 || py < 0 || px > longint'(map_w) || py > longint'(map_h)))
                    ans.cell_state = shadow_cells[(cell_of(py, rows) * cols +
                                                   cell_of(px, cols)) % CELL_TOTAL];
            end
            default: begin
                ans.overlap_found = sweep_circle(px, py, r, 1'b0);
            end
        endcase
        return ans;
    endfunction

    assign o_pending = answer_q.size();

    // follow reset, register writes and both channels
    always @(posedge i_clk) begin
        t_grid_answer want;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            map_w    = RST_MAP_WIDTH;
            map_h    = RST_MAP_HEIGHT;
            cell_len = RST_CELL_EDGE;
            rebuild_grid();
            answer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_MAP_WIDTH || i_cfg_index == CFG_MAP_HEIGHT
                             || i_cfg_index == CFG_CELL_EDGE)) begin
                case (i_cfg_index)
                    CFG_MAP_WIDTH:  map_w = i_cfg_data;
                    CFG_MAP_HEIGHT: map_h = i_cfg_data;
                    default:        cell_len = i_cfg_data;
                endcase
                rebuild_grid();
            end
            if (i_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errs++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_cell_state !== want.cell_state) begin
                        $error("cell_state expected %0d actual %0d", want.cell_state,
                               i_cell_state);
                        errs++;
                    end
                    if (i_overlap_found !== want.overlap_found) begin
                        $error("overlap_found expected %0d actual %0d", want.overlap_found,
                               i_overlap_found);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                answer_q.push_back(apply_grid_op(i_op, longint'(i_point_x),
                                                 longint'(i_point_y),
                                                 longint'(i_circle_radius)));
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/grid_circle_visibility_map_unit_test.sv
`default_nettype none

module grid_circle_visibility_map_unit_test import gcv_pkg::*;;

    localparam int CYCLE_LIMIT = 100_000_000;
    localparam int CLEAR_WAIT  = 2 * MAX_DIM + CELL_TOTAL + 64;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_index = CFG_MAP_WIDTH;
    logic [15:0]            i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_op = OP_AGE;
    logic signed [IN_W-1:0] i_point_x = '0;
    logic signed [IN_W-1:0] i_point_y = '0;
    logic signed [IN_W-1:0] i_circle_radius = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [1:0]             o_cell_state;
    logic                   o_overlap_found;
    int                     fail_count;
    int                     pending;

    int                     send_idle_pct = 0;
    int                     stall_pct = 0;
    int                     cycle_count = 0;
    int                     op_seen [4];
    int                     item_total = 0;
    int                     setting_total = 1;
    int                     map_w = RST_MAP_WIDTH;
    int                     map_h = RST_MAP_HEIGHT;
    int                     cell_len = RST_CELL_EDGE;
    int                     last_x = 0;
    int                     last_y = 0;

    grid_circle_visibility_map_unit u_top (.*);

    grid_circle_visibility_map_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_circle_radius (i_circle_radius),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_cell_state    (o_cell_state),
        .i_overlap_found (o_overlap_found),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #10 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one input transaction, with random sender gaps before it
    task automatic send_grid_op(logic [1:0] op, int px, int py, int r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_point_x       <= px[IN_W-1:0];
        i_point_y       <= py[IN_W-1:0];
        i_circle_radius <= r[IN_W-1:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        op_seen[op]++;
        item_total++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // new grid geometry, written only once the block is quiet
    task automatic set_geometry(int w, int h, int e);
        drain_results();
        map_w    = w;
        map_h    = h;
        cell_len = (e == 0) ? 1 : e;
        setting_total++;
        for (int k = 0; k < 3; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= (k == 0) ? CFG_MAP_WIDTH : ((k == 1) ? CFG_MAP_HEIGHT
                                                                : CFG_CELL_EDGE);
            i_cfg_data  <= (k == 0) ? w[15:0] : ((k == 1) ? h[15:0] : e[15:0]);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            repeat (CLEAR_WAIT) @(posedge i_clk);
        end
    endtask

    // mostly well-formed age/reveal/read/query traffic near the map, some noise
    task automatic random_grid_op();
        int pick, span_x, span_y, px, py, r;
        pick   = $urandom_range(99);
        span_x = ((map_w < 64 * cell_len) ? map_w : 64 * cell_len) + 2 * cell_len;
        span_y = ((map_h < 64 * cell_len) ? map_h : 64 * cell_len) + 2 * cell_len;
        px = $urandom_range(span_x) - cell_len;
        py = $urandom_range(span_y) - cell_len;
        r  = $urandom_range(3 * cell_len);
        if ($urandom_range(9) == 0) r = -$urandom_range(cell_len + 5);
        if (pick < 3) begin
            send_grid_op(OP_AGE, px, py, r);
        end else if (pick < 5) begin
            send_grid_op(2'($urandom), $urandom, $urandom, $urandom);
        end else if (pick < 40) begin
            last_x = px;
            last_y = py;
            send_grid_op(OP_REVEAL, px, py, r);
        end else if (pick < 72) begin
            if (pick < 60) begin
                px = last_x + $urandom_range(2 * cell_len) - cell_len;
                py = last_y + $urandom_range(2 * cell_len) - cell_len;
            end
            send_grid_op(OP_READ, px, py, r);
        end else begin
            if (pick < 88) begin
                px = last_x + $urandom_range(4 * cell_len) - 2 * cell_len;
                py = last_y + $urandom_range(4 * cell_len) - 2 * cell_len;
            end
            send_grid_op(OP_QUERY, px, py, r);
        end
    endtask

    initial begin
        int settings [7][3];
        settings = '{'{1024, 1024, 16}, '{64, 64, 1}, '{0, 0, 0}, '{65535, 65535, 65535},
                     '{100, 37, 7}, '{65535, 65535, 1}, '{1000, 700, 16}};
        foreach (op_seen[k]) op_seen[k] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges of the map, extremes of the fields, every op
        send_grid_op(OP_READ, 0, 0, 0);
        send_grid_op(OP_REVEAL, 0, 0, 0);
        send_grid_op(OP_READ, 0, 0, 0);
        send_grid_op(OP_REVEAL, 1024, 1024, 5);
        send_grid_op(OP_READ, 1024, 1024, 0);
        send_grid_op(OP_READ, 1025, 10, 0);
        send_grid_op(OP_READ, -1, 10, 0);
        send_grid_op(OP_QUERY, 1030, 1030, 6);
        send_grid_op(OP_QUERY, 1040, 1040, 6);
        send_grid_op(OP_REVEAL, 500, 500, -131072);
        send_grid_op(OP_READ, 500, 500, 0);
        send_grid_op(OP_QUERY, 515, 500, 14);
        send_grid_op(OP_QUERY, 517, 500, -3);
        send_grid_op(OP_REVEAL, -2000, 300, 1999);
        send_grid_op(OP_REVEAL, 131071, 131071, 131071);
        send_grid_op(OP_QUERY, -131072, -131072, 131071);
        send_grid_op(OP_READ, 131071, 131071, -1);
        send_grid_op(OP_READ, -131072, -131072, 131071);
        send_grid_op(OP_AGE, 0, 0, 0);
        send_grid_op(OP_READ, 600, 600, 0);
        send_grid_op(OP_QUERY, 600, 600, 131071);
        send_grid_op(OP_REVEAL, 300, 300, 40);
        send_grid_op(OP_QUERY, 300, 300, 0);
        send_grid_op(OP_READ, 300, 300, 0);

        for (int s = 0; s < 7; s++) begin
            if (s > 0) set_geometry(settings[s][0], settings[s][1], settings[s][2]);
            for (int n = 0; n < 230; n++) begin
                if (item_total < 550) begin
                    send_idle_pct = 6;
                    stall_pct     = 73;
                end else if (item_total < 1100) begin
                    send_idle_pct = 73;
                    stall_pct     = 6;
                end else begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                random_grid_op();
            end
        end

        drain_results();
        $display("covered %0d transactions over %0d grid geometries", item_total,
                 setting_total);
        $display("ages %0d, reveals %0d, reads %0d, overlap queries %0d",
                 op_seen[OP_AGE], op_seen[OP_REVEAL], op_seen[OP_READ], op_seen[OP_QUERY]);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
